// ===== rtl/core/gdil_pkg.sv =====
// ----------------------------------------------------------------------------
// gdil_pkg
// Shared types, codes and the microprogram of the grid obstacle dilation block.
// ----------------------------------------------------------------------------
package gdil_pkg;

    localparam int DIM_W  = 9;
    localparam int RAD_W  = 5;
    localparam int CELL_W = 8;
    localparam int LEFT_W = RAD_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_INFLATE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_RADIUS = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] cell_value;
    } gdil_in_t;

    typedef struct packed {
        logic              status;
        logic [CELL_W-1:0] read_value;
    } gdil_out_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } gdil_cfg_t;

    // datapath controls carried in each microword
    typedef struct packed {
        logic in_ready;
        logic mem_op;
        logic out_load;
        logic outer_clr;
        logic outer_inc;
        logic inner_clr;
        logic inner_run;
        logic pass;
    } gdil_ctl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic inflate;
        logic slot_free;
        logic no_work;
        logic inner_last;
        logic outer_last;
    } gdil_stat_t;

    localparam int PC_W   = 4;
    localparam int COND_W = 3;

    localparam logic [COND_W-1:0] COND_NEXT   = 3'd0;
    localparam logic [COND_W-1:0] COND_GOTO   = 3'd1;
    localparam logic [COND_W-1:0] COND_ACCEPT = 3'd2;
    localparam logic [COND_W-1:0] COND_SLOT   = 3'd3;
    localparam logic [COND_W-1:0] COND_SKIP   = 3'd4;
    localparam logic [COND_W-1:0] COND_INNER  = 3'd5;
    localparam logic [COND_W-1:0] COND_LOOP   = 3'd6;

    localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] ST_CELL_OP  = 4'd1;
    localparam logic [PC_W-1:0] ST_PUSH     = 4'd2;
    localparam logic [PC_W-1:0] ST_INF_INIT = 4'd3;
    localparam logic [PC_W-1:0] ST_ROW_RUN  = 4'd4;
    localparam logic [PC_W-1:0] ST_ROW_NEXT = 4'd5;
    localparam logic [PC_W-1:0] ST_COL_INIT = 4'd6;
    localparam logic [PC_W-1:0] ST_COL_RUN  = 4'd7;
    localparam logic [PC_W-1:0] ST_COL_NEXT = 4'd8;
    localparam logic [PC_W-1:0] ST_INF_DONE = 4'd9;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        gdil_ctl_t         ctl;
    } gdil_uword_t;

    function automatic gdil_uword_t gdil_ucode(input logic [PC_W-1:0] pc);
        gdil_uword_t uw;
        uw = '0;
        uw.cond = COND_NEXT;
        uw.target = ST_IDLE;
        case (pc)
            ST_IDLE:
            begin
                uw.ctl.in_ready = 1'b1;
                uw.cond = COND_ACCEPT;
                uw.target = ST_INF_INIT;
            end
            ST_CELL_OP:
            begin
                uw.ctl.mem_op = 1'b1;
            end
            ST_PUSH:
            begin
                uw.ctl.out_load = 1'b1;
                uw.cond = COND_SLOT;
                uw.target = ST_IDLE;
            end
            ST_INF_INIT:
            begin
                uw.ctl.outer_clr = 1'b1;
                uw.ctl.inner_clr = 1'b1;
                uw.cond = COND_SKIP;
                uw.target = ST_PUSH;
            end
            ST_ROW_RUN:
            begin
                uw.ctl.inner_run = 1'b1;
                uw.cond = COND_INNER;
            end
            ST_ROW_NEXT:
            begin
                uw.ctl.outer_inc = 1'b1;
                uw.ctl.inner_clr = 1'b1;
                uw.cond = COND_LOOP;
                uw.target = ST_ROW_RUN;
            end
            ST_COL_INIT:
            begin
                uw.ctl.outer_clr = 1'b1;
                uw.ctl.inner_clr = 1'b1;
                uw.ctl.pass = 1'b1;
            end
            ST_COL_RUN:
            begin
                uw.ctl.inner_run = 1'b1;
                uw.ctl.pass = 1'b1;
                uw.cond = COND_INNER;
            end
            ST_COL_NEXT:
            begin
                uw.ctl.outer_inc = 1'b1;
                uw.ctl.inner_clr = 1'b1;
                uw.ctl.pass = 1'b1;
                uw.cond = COND_LOOP;
                uw.target = ST_COL_RUN;
            end
            ST_INF_DONE:
            begin
                uw.cond = COND_GOTO;
                uw.target = ST_PUSH;
            end
            default:
            begin
                uw.cond = COND_GOTO;
                uw.target = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/core/gdil_sequencer.sv =====
// ----------------------------------------------------------------------------
// gdil_sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module gdil_sequencer
    import gdil_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gdil_stat_t stat,
    output gdil_ctl_t  ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;
    gdil_uword_t     uw;

    assign uw     = gdil_ucode(pc_reg);
    assign ctl    = uw.ctl;
    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:   pc_next = pc_inc;
            COND_GOTO:   pc_next = uw.target;
            COND_ACCEPT: pc_next = !stat.accept ? pc_reg : (stat.inflate ? uw.target : pc_inc);
            COND_SLOT:   pc_next = stat.slot_free ? uw.target : pc_reg;
            COND_SKIP:   pc_next = stat.no_work ? uw.target : pc_inc;
            COND_INNER:  pc_next = stat.inner_last ? pc_inc : pc_reg;
            COND_LOOP:   pc_next = stat.outer_last ? pc_inc : uw.target;
            default:     pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/gdil_datapath.sv =====
// ----------------------------------------------------------------------------
// gdil_datapath
// Grid and dilation memories, sweep counters, window run counter and the
// result register.
// ----------------------------------------------------------------------------
module gdil_datapath
    import gdil_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gdil_cfg_t  cfg,
    input  gdil_ctl_t  ctl,
    output gdil_stat_t stat,
    input  logic       req_valid,
    input  gdil_in_t   req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output gdil_out_t  rsp
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] y,
                                                input logic [DIM_W-1:0] x);
        return AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
    endfunction

    logic [CELL_W-1:0] grid_mem [CELLS];
    logic              hmem [CELLS];

    gdil_in_t          req_reg;
    logic [CELL_W-1:0] grid_rd_reg;
    logic              hmem_rd_reg;

    logic [DIM_W-1:0]  k_reg, k_next;
    logic [DIM_W-1:0]  outer_reg, outer_next;
    logic [DIM_W-1:0]  s2_k_reg;
    logic              s2_valid_reg;
    logic              s2_real_reg;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              rsp_valid_reg, rsp_valid_next;
    gdil_out_t         rsp_reg, rsp_next;

    logic              accept;
    logic              is_write, is_read, oor;
    logic [DIM_W-1:0]  in_x, in_y;
    logic [DIM_W-1:0]  lim, outer_lim, end_m1;
    logic [DIM_W-1:0]  r_ext, wpos;
    logic              rd_real, nz, hit, wvalid;
    logic              slot_free, load;
    logic [LEFT_W-1:0] left_full;

    logic              grid_re, grid_we;
    logic [AW-1:0]     grid_raddr, grid_waddr;
    logic [CELL_W-1:0] grid_wdata;
    logic              hmem_re, hmem_we;
    logic [AW-1:0]     hmem_raddr, hmem_waddr;

    assign accept   = req_valid && ctl.in_ready;
    assign in_x     = DIM_W'(req_reg.cell_x);
    assign in_y     = DIM_W'(req_reg.cell_y);
    assign is_write = (req_reg.func == FUNC_WRITE);
    assign is_read  = (req_reg.func == FUNC_READ);
    assign oor      = (is_write || is_read) && ((in_x >= cfg.width) || (in_y >= cfg.height));

    assign r_ext     = DIM_W'(cfg.radius);
    assign lim       = ctl.pass ? cfg.height : cfg.width;
    assign outer_lim = ctl.pass ? cfg.width : cfg.height;
    assign end_m1    = lim + r_ext - 1'b1;
    assign rd_real   = ctl.inner_run && (k_reg < lim);

    // window run: a hit lasts 2r-1 steps past the last occupied sample
    assign nz        = s2_real_reg && (ctl.pass ? hmem_rd_reg : (grid_rd_reg != '0));
    assign hit       = nz || (left_reg != '0);
    assign left_full = LEFT_W'({cfg.radius, 1'b0}) - 1'b1;
    assign wvalid    = s2_valid_reg && (s2_k_reg >= r_ext);
    assign wpos      = s2_k_reg - r_ext;

    always_comb
    begin
        if (!s2_valid_reg)
        begin
            left_next = '0;
        end
        else if (nz)
        begin
            left_next = left_full;
        end
        else if (left_reg != '0)
        begin
            left_next = left_reg - 1'b1;
        end
        else
        begin
            left_next = '0;
        end
    end

    // pass 0 dilates rows of the grid into hmem, pass 1 dilates columns back
    assign grid_re    = (ctl.mem_op && is_read && !oor) || (rd_real && !ctl.pass);
    assign grid_raddr = ctl.mem_op ? cell_addr(in_y, in_x) : cell_addr(outer_reg, k_reg);
    assign grid_we    = (ctl.mem_op && is_write && !oor) || (wvalid && ctl.pass && hit);
    assign grid_waddr = ctl.mem_op ? cell_addr(in_y, in_x) : cell_addr(wpos, outer_reg);
    assign grid_wdata = ctl.mem_op ? req_reg.cell_value : CELL_W'(1);

    assign hmem_re    = rd_real && ctl.pass;
    assign hmem_raddr = cell_addr(k_reg, outer_reg);
    assign hmem_we    = wvalid && !ctl.pass;
    assign hmem_waddr = cell_addr(outer_reg, wpos);

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re)
        begin
            grid_rd_reg <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hmem_we)
        begin
            hmem[hmem_waddr] <= hit;
        end
        if (hmem_re)
        begin
            hmem_rd_reg <= hmem[hmem_raddr];
        end
    end

    always_comb
    begin
        if (ctl.inner_clr)
        begin
            k_next = '0;
        end
        else if (ctl.inner_run)
        begin
            k_next = k_reg + 1'b1;
        end
        else
        begin
            k_next = k_reg;
        end

        if (ctl.outer_clr)
        begin
            outer_next = '0;
        end
        else if (ctl.outer_inc)
        begin
            outer_next = outer_reg + 1'b1;
        end
        else
        begin
            outer_next = outer_reg;
        end
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign load      = ctl.out_load && slot_free;

    always_comb
    begin
        rsp_next.status     = oor;
        rsp_next.read_value = (is_read && !oor) ? grid_rd_reg : '0;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            outer_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            s2_real_reg   <= 1'b0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            outer_reg     <= outer_next;
            s2_valid_reg  <= ctl.inner_run;
            s2_real_reg   <= rd_real;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_k_reg <= k_reg;
        if (accept)
        begin
            req_reg <= req;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign stat.accept     = accept;
    assign stat.inflate    = (req.func == FUNC_INFLATE);
    assign stat.slot_free  = slot_free;
    assign stat.no_work    = (cfg.width == '0) || (cfg.height == '0) || (cfg.radius == '0);
    assign stat.inner_last = (k_reg == end_m1);
    assign stat.outer_last = (outer_reg == outer_lim - 1'b1);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/grid_obstacle_dilation.sv =====
// ----------------------------------------------------------------------------
// grid_obstacle_dilation
// Byte occupancy grid with cell write, cell read and square obstacle
// inflation, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A cell write or read passes through acceptance, memory access and the result
// register before the next word is accepted; the result register lets the next
// word be accepted while a result waits. An inflate word sweeps the grid twice
// through single-ported memories, rows then columns, one cell a cycle. When
// width, height or radius is zero both sweeps are skipped. The memories need
// no clearing pass.
// ----------------------------------------------------------------------------
module grid_obstacle_dilation
    import gdil_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  gdil_in_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output gdil_out_t             rsp
);

    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] map_height_reg;
    logic [RAD_W-1:0] radius_reg;
    gdil_cfg_t        cfg;
    gdil_ctl_t        ctl;
    gdil_stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_W'(256);
            map_height_reg <= DIM_W'(256);
            radius_reg     <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MAP_WIDTH:      map_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT:     map_height_reg <= cfg_data[DIM_W-1:0];
                CFG_INFLATE_RADIUS: radius_reg     <= cfg_data[RAD_W-1:0];
                default:            ;
            endcase
        end
    end

    // saturate to the built size
    assign cfg.width  = (int'(map_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : map_width_reg;
    assign cfg.height = (int'(map_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                            : map_height_reg;
    assign cfg.radius = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;

    assign req_ready = ctl.in_ready;

    gdil_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    gdil_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ctl       (ctl),
        .stat      (stat),
        .req_valid (req_valid),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
